[design/boot_keyboard_report_to_key_events_defines.svh]
// Assertion macros for the boot keyboard report decoder.
`ifndef BOOT_KEYBOARD_REPORT_TO_KEY_EVENTS_DEFINES_SVH
`define BOOT_KEYBOARD_REPORT_TO_KEY_EVENTS_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BKR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BKR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/bkr_pkg.sv]
// Package for the boot keyboard report decoder: sizes, item types, key code table.
`timescale 1ns / 1ps

package bkr_pkg;

  localparam int KEY_SLOTS    = 6;
  localparam int INPUT_SLOTS  = 6;
  localparam int SLOTS        = (KEY_SLOTS < INPUT_SLOTS) ? KEY_SLOTS : INPUT_SLOTS;
  localparam int MOD_BASE     = 224;
  localparam int MOD_COUNT    = 8;
  localparam int RESERVED_MAX = 3;
  localparam int EVENTS       = MOD_COUNT + 2 * SLOTS;

  typedef struct packed {
    logic       transfer_ok;
    logic [7:0] modifier_bits;
    logic [7:0] scan_slot0;
    logic [7:0] scan_slot1;
    logic [7:0] scan_slot2;
    logic [7:0] scan_slot3;
    logic [7:0] scan_slot4;
    logic [7:0] scan_slot5;
  } report_t;

  typedef struct packed {
    logic [7:0] key_code;
    logic       pressed;
    logic       last_of_report;
  } key_event_t;

  typedef struct packed {
    logic       rel_valid;
    logic [7:0] rel_code;
    logic       prs_valid;
    logic [7:0] prs_code;
  } lane_res_t;

  localparam logic [7:0] KEYCODE_ROM [256] = '{
    8'd0,   8'd0,   8'd0,   8'd0,   8'd30,  8'd48,  8'd46,  8'd32,
    8'd18,  8'd33,  8'd34,  8'd35,  8'd23,  8'd36,  8'd37,
    8'd38,  8'd50,  8'd49,  8'd24,  8'd25,  8'd16,  8'd19,  8'd31,
    8'd20,  8'd22,  8'd47,  8'd17,  8'd45,  8'd21,  8'd44,
    8'd2,   8'd3,   8'd4,   8'd5,   8'd6,   8'd7,   8'd8,   8'd9,
    8'd10,  8'd11,  8'd28,  8'd1,   8'd14,  8'd15,  8'd57,
    8'd12,  8'd13,  8'd26,  8'd27,  8'd43,  8'd43,  8'd39,  8'd40,
    8'd41,  8'd51,  8'd52,  8'd53,  8'd58,  8'd59,  8'd60,
    8'd61,  8'd62,  8'd63,  8'd64,  8'd65,  8'd66,  8'd67,  8'd68,
    8'd87,  8'd88,  8'd99,  8'd70,  8'd119, 8'd110, 8'd102,
    8'd104, 8'd111, 8'd107, 8'd109, 8'd106, 8'd105, 8'd108, 8'd103,
    8'd69,  8'd98,  8'd55,  8'd74,  8'd78,  8'd96,  8'd79,
    8'd80,  8'd81,  8'd75,  8'd76,  8'd77,  8'd71,  8'd72,  8'd73,
    8'd82,  8'd83,  8'd86,  8'd127, 8'd116, 8'd117, 8'd183,
    8'd184, 8'd185, 8'd186, 8'd187, 8'd188, 8'd189, 8'd190, 8'd191,
    8'd192, 8'd193, 8'd194, 8'd134, 8'd138, 8'd130, 8'd132,
    8'd128, 8'd129, 8'd131, 8'd137, 8'd133, 8'd135, 8'd136, 8'd113,
    8'd115, 8'd114, 8'd0,   8'd0,   8'd0,   8'd121, 8'd0,
    8'd89,  8'd93,  8'd124, 8'd92,  8'd94,  8'd95,  8'd0,   8'd0,
    8'd0,   8'd122, 8'd123, 8'd90,  8'd91,  8'd85,  8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd29,
    8'd42,  8'd56,  8'd125, 8'd97,  8'd54,  8'd100, 8'd126, 8'd164,
    8'd166, 8'd165, 8'd163, 8'd161, 8'd115, 8'd114, 8'd113,
    8'd150, 8'd158, 8'd159, 8'd128, 8'd136, 8'd177, 8'd178, 8'd176,
    8'd142, 8'd152, 8'd173, 8'd140, 8'd0,   8'd0,   8'd0,
    8'd0
  };

endpackage

[design/bkr_lane.sv]
// One slot lane: release of the old scancode and press of the new one.
`timescale 1ns / 1ps

module bkr_lane (
  input  logic [7:0]        old_code,
  input  logic [7:0]        fresh_code,
  input  logic [7:0]        old_set   [bkr_pkg::SLOTS],
  input  logic [7:0]        fresh_set [bkr_pkg::SLOTS],
  output bkr_pkg::lane_res_t res
);

  always_comb begin
    logic old_kept;
    logic fresh_known;
    logic [7:0] rel_map;
    logic [7:0] prs_map;
    old_kept    = 1'b0;
    fresh_known = 1'b0;
    for (int i = 0; i < bkr_pkg::SLOTS; i++) begin
      old_kept    = old_kept    | (fresh_set[i] == old_code);
      fresh_known = fresh_known | (old_set[i] == fresh_code);
    end
    rel_map = bkr_pkg::KEYCODE_ROM[old_code];
    prs_map = bkr_pkg::KEYCODE_ROM[fresh_code];
    res.rel_valid = (old_code > 8'(bkr_pkg::RESERVED_MAX)) && !old_kept && (rel_map != 8'd0);
    res.rel_code  = rel_map;
    res.prs_valid = (fresh_code > 8'(bkr_pkg::RESERVED_MAX)) && !fresh_known
                    && (prs_map != 8'd0);
    res.prs_code  = prs_map;
  end

endmodule

[design/bkr_merge.sv]
// Event buffer and output register: merges modifier and lane events, sends one per cycle when not stalled.
`timescale 1ns / 1ps

module bkr_merge (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  logic [7:0]            modifier_bits,
  input  bkr_pkg::lane_res_t    lane_res [bkr_pkg::SLOTS],
  output logic                  empty,
  output logic                  key_valid,
  input  logic                  key_ready,
  output bkr_pkg::key_event_t   key_item
);

  localparam int N = bkr_pkg::EVENTS;

  logic [N-1:0] mask;
  logic [N-1:0] mask_next;
  logic [7:0]   code    [N];
  logic [N-1:0] pressed;
  logic [7:0]   code_next [N];
  logic [N-1:0] pressed_next;
  logic [N-1:0] lowest;
  logic [N-1:0] remaining;
  logic [7:0]   sel_code;
  logic         sel_pressed;
  logic         pop;

  always_comb begin
    for (int k = 0; k < bkr_pkg::MOD_COUNT; k++) begin
      code_next[k]    = bkr_pkg::KEYCODE_ROM[bkr_pkg::MOD_BASE + k];
      pressed_next[k] = modifier_bits[k];
      mask_next[k]    = 1'b1;
    end
    for (int s = 0; s < bkr_pkg::SLOTS; s++) begin
      code_next[bkr_pkg::MOD_COUNT + 2*s]        = lane_res[s].rel_code;
      pressed_next[bkr_pkg::MOD_COUNT + 2*s]     = 1'b0;
      mask_next[bkr_pkg::MOD_COUNT + 2*s]        = lane_res[s].rel_valid;
      code_next[bkr_pkg::MOD_COUNT + 2*s + 1]    = lane_res[s].prs_code;
      pressed_next[bkr_pkg::MOD_COUNT + 2*s + 1] = 1'b1;
      mask_next[bkr_pkg::MOD_COUNT + 2*s + 1]    = lane_res[s].prs_valid;
    end
  end

  assign lowest    = mask & (~mask + {{(N-1){1'b0}}, 1'b1});
  assign remaining = mask & ~lowest;
  assign empty     = (mask == '0);
  assign pop       = !empty && (!key_valid || key_ready);

  always_comb begin
    sel_code    = 8'd0;
    sel_pressed = 1'b0;
    for (int k = 0; k < N; k++) begin
      sel_code    = sel_code    | ({8{lowest[k]}} & code[k]);
      sel_pressed = sel_pressed | (lowest[k] & pressed[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask      <= '0;
      key_valid <= 1'b0;
    end else begin
      if (load) begin
        mask <= mask_next;
      end else if (pop) begin
        mask <= remaining;
      end
      if (pop) begin
        key_valid <= 1'b1;
      end else if (key_ready) begin
        key_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      code    <= code_next;
      pressed <= pressed_next;
    end
    if (pop) begin
      key_item.key_code       <= sel_code;
      key_item.pressed        <= sel_pressed;
      key_item.last_of_report <= (remaining == '0);
    end
  end

endmodule

[design/boot_keyboard_report_to_key_events.sv]
// Top level of the boot keyboard report decoder: slot lanes, scancode store, event merge.
//
//  channel | signals                               | item
//  --------+---------------------------------------+---------------------------
//  report  | report_valid report_ready report_item | modifier byte, six slots
//  key     | key_valid key_ready key_item          | key code, pressed, last
//
// A good report yields 8 to 20 key items, one per cycle from the event buffer
// while key is not stalled; the buffer is loaded first, then hands out the items.
// A failed report is taken without loading the buffer.
// The next report is taken once the buffer has handed its last item to the
// output register. Reset clears the old scancodes, the buffer and key_valid.
// A stall on key holds the output register and the buffer behind it.
`timescale 1ns / 1ps
`include "boot_keyboard_report_to_key_events_defines.svh"

module boot_keyboard_report_to_key_events (
  input  logic                clk,
  input  logic                rst,
  input  logic                report_valid,
  output logic                report_ready,
  input  bkr_pkg::report_t    report_item,
  output logic                key_valid,
  input  logic                key_ready,
  output bkr_pkg::key_event_t key_item
);

  logic [7:0]         scans_all [bkr_pkg::INPUT_SLOTS];
  logic [7:0]         fresh     [bkr_pkg::SLOTS];
  logic [7:0]         previous_scans [bkr_pkg::SLOTS];
  bkr_pkg::lane_res_t lane_res  [bkr_pkg::SLOTS];
  logic               take;
  logic               load;
  logic               empty;

  assign scans_all[0] = report_item.scan_slot0;
  assign scans_all[1] = report_item.scan_slot1;
  assign scans_all[2] = report_item.scan_slot2;
  assign scans_all[3] = report_item.scan_slot3;
  assign scans_all[4] = report_item.scan_slot4;
  assign scans_all[5] = report_item.scan_slot5;

  assign report_ready = empty;
  assign take         = report_valid && report_ready;
  assign load         = take && report_item.transfer_ok;

  for (genvar s = 0; s < bkr_pkg::SLOTS; s++) begin : g_lane
    assign fresh[s] = scans_all[s];

    bkr_lane u_lane (
      .old_code   (previous_scans[s]),
      .fresh_code (fresh[s]),
      .old_set    (previous_scans),
      .fresh_set  (fresh),
      .res        (lane_res[s])
    );

    always_ff @(posedge clk) begin
      if (rst) begin
        previous_scans[s] <= 8'd0;
      end else if (load) begin
        previous_scans[s] <= fresh[s];
      end
    end
  end

  bkr_merge u_merge (
    .clk           (clk),
    .rst           (rst),
    .load          (load),
    .modifier_bits (report_item.modifier_bits),
    .lane_res      (lane_res),
    .empty         (empty),
    .key_valid     (key_valid),
    .key_ready     (key_ready),
    .key_item      (key_item)
  );

  `BKR_ASSERT_NEXT(a_load_fills, load, !report_ready, "good report left buffer empty")
  `BKR_ASSERT_NOW(a_hold_until_last, key_valid && !key_item.last_of_report, !report_ready,
                  "report taken before last item")
  `BKR_ASSERT_NEXT(a_no_gap, key_valid && key_ready && !key_item.last_of_report, key_valid,
                   "gap inside a report")

endmodule
